### rtl/bcla_pkg.sv
// ----------------------------------------------------------------------------
// bcla_pkg: shared types and constants for the climb ladder allocator
// Field widths, the store size, the cell operation codes and the control
// state encoding used by the cell chain and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bcla_pkg;

   // Field widths
   localparam int HEIGHT_W = 24;
   localparam int INDEX_W  = 32;
   localparam int BUDGET_W = 32;
   localparam int LADDER_W = 5;

   // Number of cells in the sorted climb store
   localparam int MAX_LADDERS = 16;
   localparam int CNT_W       = $clog2(MAX_LADDERS + 1);

   // Configuration register map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_BRICK_BUDGET = 1'b0;
   localparam logic REG_LADDER_COUNT = 1'b1;

   // Operation broadcast to every cell of the chain
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_INSERT,
      OP_EVICT
   } cell_op_type;

   // What one cell shows its neighbors
   typedef struct packed {
      logic [HEIGHT_W-1:0] value;
      logic                valid;
      logic                gt;    // holds a climb above the broadcast climb
      logic                le;    // holds a climb at or below the broadcast climb
   } cell_nb_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } ctrl_state_type;

endpackage

`default_nettype wire

### rtl/bcla_req_if.sv
// ----------------------------------------------------------------------------
// bcla_req_if: height channel
// Valid/ready channel that carries one building of a row per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcla_req_if import bcla_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [HEIGHT_W-1:0] height;
   logic                first_of_row;
   logic                last_of_row;

   modport source (output valid, output height, output first_of_row,
                   output last_of_row, input ready);
   modport sink (input valid, input height, input first_of_row,
                 input last_of_row, output ready);
endinterface

`default_nettype wire

### rtl/bcla_rsp_if.sv
// ----------------------------------------------------------------------------
// bcla_rsp_if: result channel
// Valid/ready channel that carries the furthest index of a row per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcla_rsp_if import bcla_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] furthest_index;
   logic               reached_end;

   modport source (output valid, output furthest_index, output reached_end,
                   input ready);
   modport sink (input valid, input furthest_index, input reached_end,
                 output ready);
endinterface

`default_nettype wire

### rtl/bcla_cell.sv
// ----------------------------------------------------------------------------
// bcla_cell: one slot of the sorted climb store
// Holds one kept climb and its valid bit. Compares against the broadcast
// climb and takes its new value from itself, a neighbor or the climb.
// ----------------------------------------------------------------------------
`default_nettype none

module bcla_cell import bcla_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_op_type         op,
   input  wire logic [HEIGHT_W-1:0] climb,
   input  wire cell_nb_type         left_nb,   // smaller neighbor
   input  wire cell_nb_type         right_nb,  // larger neighbor
   output      cell_nb_type         self_nb
);

   logic [HEIGHT_W-1:0] value_ff, value_in;
   logic                valid_ff, valid_in;
   logic                gt, le;

   // Compare own climb against the broadcast one
   assign gt = valid_ff && (value_ff > climb);
   assign le = valid_ff && (value_ff <= climb);

   assign self_nb = '{value: value_ff, valid: valid_ff, gt: gt, le: le};

   // Pick the next content of the slot
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (op)
         OP_CLEAR: begin
            valid_in = 1'b0;
         end
         OP_INSERT: begin
            // shift larger climbs up by one, drop the new climb into the gap
            if (left_nb.gt) begin
               value_in = left_nb.value;
            end else if (gt || (!valid_ff && left_nb.valid)) begin
               value_in = climb;
            end
            valid_in = valid_ff || left_nb.valid;
         end
         OP_EVICT: begin
            // drop the smallest, shift smaller ones down, place the new climb
            if (right_nb.le) begin
               value_in = right_nb.value;
            end else if (le) begin
               value_in = climb;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // Valid bit is control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Climb value needs no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

### rtl/budgeted_climb_ladder_allocator.sv
// ----------------------------------------------------------------------------
// budgeted_climb_ladder_allocator: furthest building reached with bricks
// and ladders
// Usage:
//   req_bus carries one building height per beat, with first_of_row and
//   last_of_row marking the row. rsp_bus carries at most one result per
//   row: the furthest index and whether the whole row was climbed.
//   Rises that get a ladder are kept in a chain of MAX_LADDERS sorted cells;
//   the smallest kept rise (or the new one) is paid from the brick budget
//   once the ladders are used up.
//   An item is handled in order: the accept cycle registers the rise against
//   the previous height, then ST_APPLY runs the cell chain and the brick check
//   once the result register is free and loads any result beat into it. The
//   block takes no new item until ST_APPLY is done.
//   brick_budget and ladder_count are written over the csr_ APB port and
//   take effect at the next row start.
//   Reset empties the store and clears the row state; items before the
//   first row start see no bricks and no ladders.
//   A stalled receiver holds the result register; the next item is still
//   taken, and its chain update waits until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module budgeted_climb_ladder_allocator import bcla_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bcla_req_if.sink                   req_bus,
   bcla_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output      logic [31:0]           csr_prdata,
   output      logic                  csr_pready
);

   // Configuration registers
   logic [BUDGET_W-1:0] budget_ff;
   logic [LADDER_W-1:0] ladders_ff;
   logic                csr_write;

   // Control and row state
   ctrl_state_type      state_ff, state_in;
   logic [HEIGHT_W-1:0] prev_ff;
   logic [HEIGHT_W-1:0] climb_ff;
   logic                rise_ff;
   logic                first_ff;
   logic                last_ff;
   logic                stopped_ff, stopped_in;
   logic [BUDGET_W-1:0] bricks_ff, bricks_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [CNT_W-1:0]    limit_ff, limit_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    limit_sat;
   logic [BUDGET_W-1:0] pay;
   logic                fail;
   cell_op_type         cell_op;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic                rsp_end_ff;
   logic                res_valid;
   logic [INDEX_W-1:0]  res_index;
   logic                res_end;
   logic                out_free;
   logic                req_fire;

   // Cell chain wiring
   cell_nb_type         cells    [MAX_LADDERS];
   cell_nb_type         left_nb  [MAX_LADDERS];
   cell_nb_type         right_nb [MAX_LADDERS];

   // APB port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_LADDER_COUNT) ?
                       {{(32-LADDER_W){1'b0}}, ladders_ff} : budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff  <= '0;
         ladders_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_BRICK_BUDGET) begin
            budget_ff <= csr_pwdata;
         end else begin
            ladders_ff <= csr_pwdata[LADDER_W-1:0];
         end
      end
   end

   // Saturate the ladder count to the store size
   assign limit_sat = (32'(ladders_ff) > 32'(MAX_LADDERS)) ? CNT_W'(MAX_LADDERS)
                                                           : CNT_W'(ladders_ff);

   // Handshakes
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Chain of sorted cells, smallest climb in cell 0
   for (genvar k = 0; k < MAX_LADDERS; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign left_nb[k] = '{value: '0, valid: 1'b1, gt: 1'b0, le: 1'b0};
      end else begin : g_mid
         assign left_nb[k] = cells[k-1];
      end
      if (k == MAX_LADDERS - 1) begin : g_tail
         assign right_nb[k] = '{value: '0, valid: 1'b0, gt: 1'b0, le: 1'b0};
      end else begin : g_body
         assign right_nb[k] = cells[k+1];
      end

      bcla_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .op       (cell_op),
         .climb    (climb_ff),
         .left_nb  (left_nb[k]),
         .right_nb (right_nb[k]),
         .self_nb  (cells[k])
      );
   end

   // Capture the item and form its rise against the previous height
   always_ff @(posedge clock) begin
      if (req_fire) begin
         first_ff <= req_bus.first_of_row;
         last_ff  <= req_bus.last_of_row;
         rise_ff  <= req_bus.height > prev_ff;
         climb_ff <= req_bus.height - prev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (req_fire && (req_bus.first_of_row || !stopped_ff)) begin
         prev_ff <= req_bus.height;
      end
   end

   // Next state, chain operation, budget check and result
   always_comb begin
      state_in   = state_ff;
      cell_op    = OP_HOLD;
      count_in   = count_ff;
      limit_in   = limit_ff;
      bricks_in  = bricks_ff;
      index_in   = index_ff;
      stopped_in = stopped_ff;
      pay        = '0;
      fail       = 1'b0;
      res_valid  = 1'b0;
      res_index  = index_ff;
      res_end    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (first_ff) begin
                  // start a row: empty the store, load the budgets
                  cell_op    = OP_CLEAR;
                  count_in   = '0;
                  limit_in   = limit_sat;
                  bricks_in  = budget_ff;
                  index_in   = '0;
                  stopped_in = 1'b0;
                  if (last_ff) begin
                     res_valid = 1'b1;
                     res_index = '0;
                     res_end   = 1'b1;
                  end
               end else if (!stopped_ff) begin
                  if (rise_ff) begin
                     if (count_ff < limit_ff) begin
                        // a ladder is free
                        cell_op  = OP_INSERT;
                        count_in = count_ff + 1'b1;
                        pay      = '0;
                     end else if ((count_ff != '0) && (cells[0].value < climb_ff)) begin
                        // move the ladder off the smallest climb
                        cell_op = OP_EVICT;
                        pay     = BUDGET_W'(cells[0].value);
                     end else begin
                        pay = BUDGET_W'(climb_ff);
                     end
                     if (pay > bricks_ff) begin
                        fail = 1'b1;
                     end else begin
                        bricks_in = bricks_ff - pay;
                     end
                  end
                  if (fail) begin
                     stopped_in = 1'b1;
                     res_valid  = 1'b1;
                     res_index  = index_ff;
                     res_end    = 1'b0;
                  end else begin
                     if (index_ff != '1) begin
                        index_in = index_ff + 1'b1;
                     end
                     if (last_ff) begin
                        res_valid = 1'b1;
                        res_index = index_in;
                        res_end   = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         limit_ff   <= '0;
         bricks_ff  <= '0;
         index_ff   <= '0;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         limit_ff   <= limit_in;
         bricks_ff  <= bricks_in;
         index_ff   <= index_in;
         stopped_ff <= stopped_in;
      end
   end

   // Result register: load a new beat, drop it once taken
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_index_ff <= res_index;
         rsp_end_ff   <= res_end;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.furthest_index = rsp_index_ff;
   assign rsp_bus.reached_end    = rsp_end_ff;

endmodule

`default_nettype wire

### verif/budgeted_climb_ladder_allocator_tb.sv
// ----------------------------------------------------------------------------
// budgeted_climb_ladder_allocator_tb: self-checking bench for the allocator
// Streams rows of building heights into the block, both directed corner rows
// and random rows under several brick and ladder settings. A scoreboard
// class predicts the furthest index of each row and checks every result
// beat. Both channels idle in random bursts. At one point the result side
// holds off long enough for the block to fill and stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module budgeted_climb_ladder_allocator_tb import bcla_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Row predictor and pending result store
   class climb_scoreboard;
      typedef struct packed {
         logic [INDEX_W-1:0] furthest_index;
         logic               reached_end;
      } row_result_type;

      logic [BUDGET_W-1:0] budget_reg;
      logic [LADDER_W-1:0] ladders_reg;
      logic [HEIGHT_W-1:0] prev_height;
      logic [HEIGHT_W-1:0] climbs [MAX_LADDERS];
      int unsigned         kept;
      int unsigned         ladder_limit;
      logic [BUDGET_W-1:0] bricks_left;
      logic [INDEX_W-1:0]  bldg_index;
      logic                stopped;
      row_result_type      results_due [$];
      int unsigned         mismatches;

      function new();
         budget_reg   = '0;
         ladders_reg  = '0;
         prev_height  = '0;
         kept         = 0;
         ladder_limit = 0;
         bricks_left  = '0;
         bldg_index   = '0;
         stopped      = 1'b0;
         mismatches   = 0;
         foreach (climbs[k]) climbs[k] = '0;
      endfunction

      function void note_csr(logic reg_index, logic [31:0] value);
         if (reg_index == REG_BRICK_BUDGET) begin
            budget_reg = value;
         end else begin
            ladders_reg = value[LADDER_W-1:0];
         end
      endfunction

      // Keep the climbs sorted ascending; the store must have room
      function void insert_climb(logic [HEIGHT_W-1:0] d);
         int k;
         k = kept;
         while (k > 0 && climbs[k-1] > d) begin
            climbs[k] = climbs[k-1];
            k--;
         end
         climbs[k] = d;
         kept++;
      endfunction

      // Advance the row by one accepted beat and queue any result it causes
      function void note_item(logic [HEIGHT_W-1:0] h, logic first, logic last);
         logic [HEIGHT_W-1:0] old_height;
         logic [HEIGHT_W-1:0] d;
         logic [HEIGHT_W-1:0] pay;
         if (first) begin
            foreach (climbs[k]) climbs[k] = '0;
            kept         = 0;
            bricks_left  = budget_reg;
            ladder_limit = (ladders_reg > MAX_LADDERS) ? MAX_LADDERS : ladders_reg;
            prev_height  = h;
            bldg_index   = '0;
            stopped      = 1'b0;
         end else begin
            if (stopped) return;
            old_height  = prev_height;
            prev_height = h;
            if (h > old_height) begin
               d = h - old_height;
               if (kept < ladder_limit) begin
                  insert_climb(d);
                  pay = '0;
               end else if (kept > 0 && climbs[0] < d) begin
                  // pay the smallest kept climb and give its ladder to this one
                  pay = climbs[0];
                  for (int k = 1; k < kept; k++) climbs[k-1] = climbs[k];
                  kept--;
                  climbs[kept] = '0;
                  insert_climb(d);
               end else begin
                  pay = d;
               end
               if (BUDGET_W'(pay) > bricks_left) begin
                  stopped = 1'b1;
                  results_due.push_back('{bldg_index, 1'b0});
                  return;
               end
               bricks_left -= BUDGET_W'(pay);
            end
            if (bldg_index != '1) bldg_index++;
         end
         if (last) results_due.push_back('{bldg_index, 1'b1});
      endfunction

      function void check_result(logic [INDEX_W-1:0] idx, logic reached);
         row_result_type due;
         if (results_due.size() == 0) begin
            $error("unexpected result beat: furthest_index %0d reached_end %0b", idx, reached);
            mismatches++;
            return;
         end
         due = results_due.pop_front();
         if (idx !== due.furthest_index) begin
            $error("furthest_index: expected %0d, actual %0d", due.furthest_index, idx);
            mismatches++;
         end
         if (reached !== due.reached_end) begin
            $error("reached_end: expected %0b, actual %0b", due.reached_end, reached);
            mismatches++;
         end
      endfunction

      function int pending();
         return results_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   bcla_req_if req_bus ();
   bcla_rsp_if rsp_bus ();

   climb_scoreboard sb = new();
   bit              quiet = 1'b0;
   int              long_hold = 0;
   int              random_items = 0;

   budgeted_climb_ladder_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offer one height beat, with an optional idle burst first
   task automatic send_beat(input logic [HEIGHT_W-1:0] h, input logic first,
                            input logic last);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.height       <= h;
      req_bus.first_of_row <= first;
      req_bus.last_of_row  <= last;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_item(h, first, last);
   endtask

   // Drop valid and let every expected result drain before touching registers
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.note_csr(reg_index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // One row: either a random walk of heights or fully random heights
   task automatic send_row(input int len, input int step, input bit full_range,
                           input bit keep_last);
      int h;
      h = $urandom_range(0, 24'hFFFFFF);
      for (int i = 0; i < len; i++) begin
         if (i > 0) begin
            if (full_range) begin
               h = $urandom_range(0, 24'hFFFFFF);
            end else begin
               h = h + int'($urandom_range(0, 2 * step)) - step;
               if (h < 0) h = 0;
               if (h > 24'hFFFFFF) h = 24'hFFFFFF;
            end
         end
         send_beat(h[HEIGHT_W-1:0], i == 0, keep_last && (i == len - 1));
      end
      random_items += len;
   endtask

   // Result side: check each beat, stall in bursts, honor the long hold
   initial begin : rsp_side
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(rsp_bus.furthest_index, rsp_bus.reached_end);
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 10) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] budgets [8];
      logic [31:0] ladders [8];
      int          phase_end;
      int          len;
      int          step;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.height       = '0;
      req_bus.first_of_row = 1'b0;
      req_bus.last_of_row  = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Items before any row start: no bricks, no ladders, so the first climb
      // stops the row and the marked last beat is ignored
      send_beat(24'd0, 1'b0, 1'b0);
      send_beat(24'd5, 1'b0, 1'b0);
      send_beat(24'd9, 1'b0, 1'b1);
      settle();
      csr_write(REG_BRICK_BUDGET, 32'd10);
      csr_write(REG_LADDER_COUNT, 32'd1);

      // Single-building row at the top height
      send_beat(24'hFFFFFF, 1'b1, 1'b1);
      // Ladder, descent, paid eviction, flat step, then out of bricks
      send_beat(24'd0, 1'b1, 1'b0);
      send_beat(24'd5, 1'b0, 1'b0);
      send_beat(24'd3, 1'b0, 1'b0);
      send_beat(24'd10, 1'b0, 1'b0);
      send_beat(24'd10, 1'b0, 1'b0);
      send_beat(24'd20, 1'b0, 1'b0);
      send_beat(24'd30, 1'b0, 1'b1);
      // Descending row climbs to the end
      send_beat(24'd100, 1'b1, 1'b0);
      send_beat(24'd0, 1'b0, 1'b1);
      // Run out of bricks on the last building
      send_beat(24'd0, 1'b1, 1'b0);
      send_beat(24'd20, 1'b0, 1'b0);
      send_beat(24'd40, 1'b0, 1'b1);
      // Full-height climb on a ladder
      send_beat(24'd0, 1'b1, 1'b0);
      send_beat(24'hFFFFFF, 1'b0, 1'b1);
      // Register change inside an open row waits for the next row start
      send_beat(24'd7, 1'b1, 1'b0);
      settle();
      csr_write(REG_BRICK_BUDGET, 32'hFFFF_FFFF);
      csr_write(REG_LADDER_COUNT, 32'd0);
      send_beat(24'd8, 1'b0, 1'b1);
      // Zero ladders, full budget pays a full-height climb
      send_beat(24'd0, 1'b1, 1'b0);
      send_beat(24'hFFFFFF, 1'b0, 1'b1);
      settle();
      // Ladder count above the store size saturates
      csr_write(REG_BRICK_BUDGET, 32'd0);
      csr_write(REG_LADDER_COUNT, 32'd31);
      send_beat(24'd0, 1'b1, 1'b0);
      send_beat(24'd1, 1'b0, 1'b0);
      send_beat(24'd2, 1'b0, 1'b1);

      // Random phases, each under its own register setting
      budgets = '{32'd0, 32'hFFFF_FFFF, $urandom_range(0, 300), $urandom_range(0, 3000),
                  $urandom, $urandom_range(0, 100), $urandom_range(0, 1000),
                  $urandom_range(0, 500)};
      ladders = '{32'd16, 32'd0, 32'd31, $urandom_range(1, 4), $urandom_range(0, 31),
                  32'd2, $urandom_range(17, 31), $urandom_range(0, 16)};
      for (int p = 0; p < 8; p++) begin
         settle();
         csr_write(REG_BRICK_BUDGET, budgets[p]);
         csr_write(REG_LADDER_COUNT, ladders[p]);
         if (p == 2) long_hold = 150;
         if (p == 7) quiet = 1'b1;
         phase_end = random_items + 45;
         while (random_items < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               // stray beat outside the row framing
               send_beat(HEIGHT_W'($urandom_range(0, 24'hFFFFFF)), 1'b0,
                         1'($urandom_range(0, 1)));
               random_items++;
            end else begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
               case ($urandom_range(0, 2))
                  0: step = 4;
                  1: step = 64;
                  default: step = 1000;
               endcase
               send_row(len, step, $urandom_range(0, 5) == 0, $urandom_range(0, 9) != 0);
            end
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
